// ===== rtl/canopen_sdo_expedited_client_assert.svh =====
// Assertion helpers shared by the SDO client modules.
// Each check is sampled on the rising clock edge and is disabled while reset is high.
`ifndef CANOPEN_SDO_EXPEDITED_CLIENT_ASSERT_SVH
`define CANOPEN_SDO_EXPEDITED_CLIENT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define COSDO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define COSDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cosdo_pkg.sv =====
package cosdo_pkg;

  // Width of the tick counter. The counter saturates at its all-ones value.
  localparam int TIMER_BITS = 20;

  localparam int NODE_W    = 7;
  localparam int TIMEOUT_W = 20;
  localparam int CMP_W     = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ID = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 1'd1;
  localparam int CFG_DATA_W = 20;

  localparam logic [NODE_W-1:0]    NODE_ID_RESET = 7'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd100000;

  // Input item kinds.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Result kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Completion status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADLEN  = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_ABORT   = 3'd3;
  localparam logic [2:0] ST_BUSY    = 3'd4;

  // SDO command specifiers.
  localparam logic [7:0] CMD_DL_1B   = 8'h2F;
  localparam logic [7:0] CMD_DL_2B   = 8'h2B;
  localparam logic [7:0] CMD_DL_4B   = 8'h23;
  localparam logic [7:0] CMD_UPLOAD  = 8'h40;
  localparam logic [7:0] CMD_DL_ACK  = 8'h60;
  localparam logic [7:0] CMD_ABORT   = 8'h80;
  localparam logic [7:0] CMD_UP_1B   = 8'h4F;
  localparam logic [7:0] CMD_UP_2B   = 8'h4B;
  localparam logic [7:0] CMD_UP_4B   = 8'h43;

  // Base COB-IDs for client-to-server and server-to-client SDO frames.
  localparam logic [10:0] COB_TX_BASE = 11'h600;
  localparam logic [10:0] COB_RX_BASE = 11'h580;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 144;

  // One input item, unpacked from the stream.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] object_index;
    logic [7:0]  object_subindex;
    logic [31:0] write_value;
    logic [2:0]  write_length;
    logic [10:0] rx_identifier;
    logic [63:0] rx_payload;
  } item_t;

  // One result item, as handed from the core to the output stage.
  typedef struct packed {
    logic        result_kind;
    logic [10:0] tx_identifier;
    logic [63:0] tx_payload;
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [31:0] abort_code;
  } result_t;

endpackage

// ===== rtl/cosdo_core.sv =====
module cosdo_core
  import cosdo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  item_t                  item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                   res_valid,
  output result_t                res
);

  logic [NODE_W-1:0]     node_id;
  logic [TIMEOUT_W-1:0]  timeout_ticks;
  logic                  pending;
  logic                  pending_is_read;
  logic [15:0]           pending_index;
  logic [7:0]            pending_subindex;
  logic [TIMER_BITS-1:0] elapsed;

  logic                  pending_next;
  logic                  pending_is_read_next;
  logic [15:0]           pending_index_next;
  logic [7:0]            pending_subindex_next;
  logic [TIMER_BITS-1:0] elapsed_next;

  logic [7:0]            cmd;
  logic [31:0]           data;
  logic                  len_ok;
  logic [7:0]            rx_cmd;
  logic [15:0]           rx_index;
  logic [7:0]            rx_subindex;
  logic [31:0]           rx_high;
  logic                  rx_match;
  logic                  rx_from_node;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  timer_full;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // Download command and data for the requested length.
  always_comb begin
    len_ok = 1'b1;
    cmd    = CMD_UPLOAD;
    data   = '0;
    if (item.opcode == OP_WRITE) begin
      unique case (item.write_length)
        3'd1: begin
          cmd  = CMD_DL_1B;
          data = {24'd0, item.write_value[7:0]};
        end
        3'd2: begin
          cmd  = CMD_DL_2B;
          data = {16'd0, item.write_value[15:0]};
        end
        3'd4: begin
          cmd  = CMD_DL_4B;
          data = item.write_value;
        end
        default: begin
          len_ok = 1'b0;
        end
      endcase
    end
  end

  // Reply decode.
  assign rx_cmd       = item.rx_payload[7:0];
  assign rx_index     = item.rx_payload[23:8];
  assign rx_subindex  = item.rx_payload[31:24];
  assign rx_high      = item.rx_payload[63:32];
  assign rx_match     = (rx_index == pending_index) && (rx_subindex == pending_subindex);
  assign rx_from_node = item.rx_identifier == (COB_RX_BASE + {4'd0, node_id});

  // Saturating tick count.
  assign elapsed_inc = (elapsed != TIMER_MAX) ? elapsed + TIMER_BITS'(1) : elapsed;
  assign timer_full  = elapsed_inc == TIMER_MAX;

  // Per-item decision: next transfer state and the result, if any.
  always_comb begin
    pending_next          = pending;
    pending_is_read_next  = pending_is_read;
    pending_index_next    = pending_index;
    pending_subindex_next = pending_subindex;
    elapsed_next          = elapsed;
    res_valid             = 1'b0;
    res                   = '0;
    res.result_kind       = KIND_DONE;

    unique case (item.opcode)
      OP_WRITE, OP_READ: begin
        res_valid = 1'b1;
        if (pending) begin
          res.status = ST_BUSY;
        end else if (!len_ok) begin
          res.status = ST_BADLEN;
        end else begin
          res.result_kind       = KIND_FRAME;
          res.tx_identifier     = COB_TX_BASE + {4'd0, node_id};
          res.tx_payload        = {data, item.object_subindex, item.object_index, cmd};
          pending_next          = 1'b1;
          pending_is_read_next  = item.opcode == OP_READ;
          pending_index_next    = item.object_index;
          pending_subindex_next = item.object_subindex;
          elapsed_next          = '0;
        end
      end
      OP_FRAME: begin
        if (pending && rx_from_node) begin
          if (pending_is_read) begin
            if ((rx_cmd == CMD_UP_1B || rx_cmd == CMD_UP_2B || rx_cmd == CMD_UP_4B)
                && rx_match) begin
              res_valid      = 1'b1;
              res.status     = ST_OK;
              res.read_value = rx_high;
              pending_next   = 1'b0;
            end
          end else if (rx_cmd == CMD_DL_ACK && rx_match) begin
            res_valid    = 1'b1;
            res.status   = ST_OK;
            pending_next = 1'b0;
          end else if (rx_cmd == CMD_ABORT) begin
            res_valid      = 1'b1;
            res.status     = ST_ABORT;
            res.abort_code = rx_high;
            pending_next   = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (pending) begin
          elapsed_next = elapsed_inc;
          if (CMP_W'(elapsed_inc) >= CMP_W'(timeout_ticks) || timer_full) begin
            res_valid    = 1'b1;
            res.status   = ST_TIMEOUT;
            pending_next = 1'b0;
          end
        end
      end
    endcase
  end

  // Transfer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending          <= 1'b0;
      pending_is_read  <= 1'b0;
      pending_index    <= '0;
      pending_subindex <= '0;
      elapsed          <= '0;
    end else if (accept) begin
      pending          <= pending_next;
      pending_is_read  <= pending_is_read_next;
      pending_index    <= pending_index_next;
      pending_subindex <= pending_subindex_next;
      elapsed          <= elapsed_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id       <= NODE_ID_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      if (cfg_addr == CFG_NODE_ID) begin
        node_id <= cfg_wdata[NODE_W-1:0];
      end else if (cfg_addr == CFG_TIMEOUT) begin
        timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
      end
    end
  end

`include "canopen_sdo_expedited_client_assert.svh"

  // A request that finds a transfer in flight is answered busy.
  `COSDO_ASSERT_SAME(a_busy_reply, accept && pending && (item.opcode == OP_WRITE || item.opcode == OP_READ), res_valid && res.result_kind == KIND_DONE && res.status == ST_BUSY, "request while pending not answered busy")
  // A transfer only ends together with a finished result.
  `COSDO_ASSERT_NEXT(a_pending_holds, accept && pending && !(res_valid && res.result_kind == KIND_DONE), pending, "pending transfer dropped without a result")
  // A transmitted frame always opens a transfer.
  `COSDO_ASSERT_NEXT(a_frame_opens, accept && res_valid && res.result_kind == KIND_FRAME, pending && elapsed == '0, "request frame sent without opening a transfer")

endmodule

// ===== rtl/canopen_sdo_expedited_client.sv =====
// Channel  Dir  Handshake                 Content
// s_*      in   s_tvalid / s_tready       tuser opcode; tdata request and received frame fields
// m_*      out  m_tvalid / m_tready       tuser result kind; tdata frame and completion fields
// cfg_*    in   cfg_valid / cfg_ready     register index and write data
//
// Each item is decided in the cycle it is accepted; its result is registered and shows on
// the m_* side, so one item per clock is sustained while s_tready is high.
// A skid register holds one result while m_tready is low; s_tready drops only when it is full.
// Configuration writes are taken in every cycle (cfg_ready is always high).
// Synchronous reset clears the pending transfer and restores node 1 and a 100000-tick timeout.
module canopen_sdo_expedited_client
  import cosdo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // opcode
  input  logic [1:0]             s_tuser,
  // object_index, object_subindex, write_value, write_length, rx_identifier,
  // rx_payload, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // result_kind
  output logic                   m_tuser,
  // tx_identifier, tx_payload, status, read_value, abort_code, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  item_t   item;
  logic    accept;
  logic    res_valid;
  result_t res;
  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;
  logic    out_free;

  // Unpack the input item.
  assign item.opcode          = s_tuser;
  assign item.object_index    = s_tdata[15:0];
  assign item.object_subindex = s_tdata[23:16];
  assign item.write_value     = s_tdata[55:24];
  assign item.write_length    = s_tdata[58:56];
  assign item.rx_identifier   = s_tdata[69:59];
  assign item.rx_payload      = s_tdata[133:70];

  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  cosdo_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_addr  (cfg_index),
    .cfg_wdata (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with one skid entry behind it.
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (m_tready) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_res <= skid_res;
      end
    end else if (accept && res_valid) begin
      if (out_free) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end
  end

  // Pack the result item.
  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.result_kind;
  assign m_tdata  = {2'b00, out_res.abort_code, out_res.read_value, out_res.status,
                     out_res.tx_payload, out_res.tx_identifier};

`include "canopen_sdo_expedited_client_assert.svh"

  // The skid entry is only used behind a full output register.
  `COSDO_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid, "skid entry filled with empty output")
  // A result that meets a stalled output lands in the skid entry.
  `COSDO_ASSERT_NEXT(a_stall_to_skid, accept && res_valid && out_valid && !m_tready, skid_valid, "result lost on stalled output")
  // A draining skid entry always refills the output register.
  `COSDO_ASSERT_NEXT(a_skid_drain, skid_valid && m_tready, out_valid && !skid_valid, "skid entry not moved to output")

endmodule
